/* sv/jss_pkg.sv */
// Shared constants and widths for the shock sensor stencil core.
package jss_pkg;

  // Default build sizes.
  localparam int DEF_MAX_NX      = 64;
  localparam int DEF_MAX_NY      = 64;
  localparam int DEF_SAMPLE_BITS = 24;
  localparam int DEF_FRAC_BITS   = 16;

  // Register file layout.
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 13;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_DIMENSIONS = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SIZE_X     = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SIZE_Y     = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SIZE_Z     = 2'd3;

  // Register field widths and reset values.
  localparam int DIMS_BITS   = 2;
  localparam int SIZE_XY_BITS = 7;
  localparam int SIZE_Z_BITS = 13;
  localparam logic [DIMS_BITS-1:0]    DIMS_RESET   = 2'd1;
  localparam logic [SIZE_XY_BITS-1:0] SIZE_X_RESET = 7'd64;
  localparam logic [SIZE_XY_BITS-1:0] SIZE_Y_RESET = 7'd64;
  localparam logic [SIZE_Z_BITS-1:0]  SIZE_Z_RESET = 13'd64;

  // Plane count limits.
  localparam int MIN_SIZE   = 3;
  localparam int MAX_NZ     = 4096;
  localparam int PLANE_BITS = 12;

endpackage

/* sv/jss_store.sv */
// Two-plane sample store: one write port, one registered read port.
module jss_store import jss_pkg::*; #(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  parameter int DEPTH       = 2 * DEF_MAX_NX * DEF_MAX_NY,
  parameter int AW          = $clog2(DEPTH)
) (
  input  logic                   clk,
  input  logic                   wr_en,
  input  logic [AW-1:0]          wr_addr,
  input  logic [SAMPLE_BITS-1:0] wr_data,
  input  logic                   rd_en,
  input  logic [AW-1:0]          rd_addr,
  output logic [SAMPLE_BITS-1:0] rd_data
);

  logic [SAMPLE_BITS-1:0] mem [DEPTH];
  logic [SAMPLE_BITS-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* sv/jss_ratio.sv */
// Ratio unit: floor(2^F * sqrt(D / M)) by restoring division then bitwise square root.
module jss_ratio import jss_pkg::*; #(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [2*(SAMPLE_BITS+2)+1:0] dsum,
  input  logic [2*(SAMPLE_BITS+2)+1:0] msum,
  output logic                 done,
  output logic [FRAC_BITS:0]   sensor
);

  localparam int ACCW = 2 * (SAMPLE_BITS + 2) + 2;
  localparam int QW   = 2 * FRAC_BITS + 1;
  localparam int RTW  = FRAC_BITS + 1;
  localparam int CNTW = $clog2(QW + 1);

  typedef enum logic [1:0] {R_IDLE, R_DIV, R_SQRT} rstate_t;

  rstate_t           state_r;
  logic [CNTW-1:0]   cnt_r;
  logic [ACCW:0]     rem_r, rem_nxt;
  logic [ACCW-1:0]   div_r;
  logic [QW-1:0]     quo_r, quo_nxt;
  logic [RTW-1:0]    root_r, root_nxt;
  logic [FRAC_BITS:0] sensor_r;
  logic              done_r;
  logic [ACCW:0]     shifted;
  logic [RTW-1:0]    cand;
  logic [2*RTW-1:0]  cand_sq;

  // One quotient bit per cycle; the first step takes the integer bit.
  always_comb begin
    shifted = (cnt_r == '0) ? rem_r : {rem_r[ACCW-1:0], 1'b0};
    if (shifted >= {1'b0, div_r}) begin
      rem_nxt = shifted - {1'b0, div_r};
      quo_nxt = {quo_r[QW-2:0], 1'b1};
    end else begin
      rem_nxt = shifted;
      quo_nxt = {quo_r[QW-2:0], 1'b0};
    end
  end

  // One root bit per cycle, most significant first.
  always_comb begin
    cand    = root_r | (RTW'(1) << cnt_r);
    cand_sq = cand * cand;
    root_nxt = (cand_sq <= (2*RTW)'(quo_r)) ? cand : root_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= R_IDLE;
      done_r  <= 1'b0;
    end else begin
      unique case (state_r)
        R_IDLE: begin
          done_r <= start && (msum == '0);
          if (start) begin
            div_r <= msum;
            rem_r <= {1'b0, dsum};
            quo_r <= '0;
            cnt_r <= '0;
            if (msum == '0) begin
              sensor_r <= '0;
            end else begin
              state_r <= R_DIV;
            end
          end
        end
        R_DIV: begin
          done_r <= 1'b0;
          rem_r  <= rem_nxt;
          quo_r  <= quo_nxt;
          if (cnt_r == CNTW'(QW - 1)) begin
            cnt_r   <= CNTW'(FRAC_BITS);
            root_r  <= '0;
            state_r <= R_SQRT;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        R_SQRT: begin
          root_r <= root_nxt;
          done_r <= (cnt_r == '0);
          if (cnt_r == '0) begin
            sensor_r <= root_nxt;
            state_r  <= R_IDLE;
          end else begin
            cnt_r <= cnt_r - 1'b1;
          end
        end
        default: begin
          done_r  <= 1'b0;
          state_r <= R_IDLE;
        end
      endcase
    end
  end

  assign done   = done_r;
  assign sensor = sensor_r;

endmodule

/* sv/jameson_shock_sensor_stencil_core.sv */
// Jameson pressure shock sensor over a raster-streamed grid with a two-plane store.
// One item at a time: an item with no result only passes through the store write;
// an item with a result is paced by the single store read port (a read and a capture
// state per neighbor read) and the bit-serial ratio unit. Its result enters the output
// register before the final store write. Synchronous reset clears the counters and
// handshakes and loads the config registers' reset values; the store is not cleared.
module jameson_shock_sensor_stencil_core import jss_pkg::*; #(
  parameter int MAX_NX      = DEF_MAX_NX,
  parameter int MAX_NY      = DEF_MAX_NY,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [SAMPLE_BITS-1:0]    in_sample,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [FRAC_BITS:0]        out_sensor,
  output logic                      out_last,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int PLANE = MAX_NX * MAX_NY;
  localparam int DEPTH = 2 * PLANE;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(MAX_NX);
  localparam int RW    = $clog2(MAX_NY);
  localparam int NXW   = $clog2(MAX_NX + 1);
  localparam int NYW   = $clog2(MAX_NY + 1);
  localparam int EW    = SAMPLE_BITS + 2;
  localparam int SQW   = 2 * EW;
  localparam int ACCW  = SQW + 2;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_CAP, S_MUL, S_ACC, S_RSTART, S_RATIO, S_OUT, S_WR
  } state_t;

  state_t                  state_r;
  logic [DIMS_BITS-1:0]    dims_r;
  logic [SIZE_XY_BITS-1:0] size_x_r, size_y_r;
  logic [SIZE_Z_BITS-1:0]  size_z_r;
  logic [CW-1:0]           col_r;
  logic [RW-1:0]           row_r;
  logic [PLANE_BITS-1:0]   plane_r;
  logic [SAMPLE_BITS-1:0]  s_r, ctr_r, a_r, cv_r;
  logic [2:0]              k_r;
  logic                    last_r;
  logic [SQW-1:0]          dsq_r, msq_r;
  logic [ACCW-1:0]         dsum_r, msum_r;
  logic                    out_valid_r, out_last_r;
  logic [FRAC_BITS:0]      out_sensor_r;

  // Effective register values after clamping.
  logic [DIMS_BITS-1:0] dims;
  logic [NXW-1:0]       nx;
  logic [NYW-1:0]       ny;
  logic [SIZE_Z_BITS-1:0] nz;

  always_comb begin
    dims = (dims_r == '0) ? DIMS_BITS'(1) : dims_r;
    if (32'(size_x_r) < MIN_SIZE)    nx = NXW'(MIN_SIZE);
    else if (32'(size_x_r) > MAX_NX) nx = NXW'(MAX_NX);
    else                             nx = NXW'(size_x_r);
    if (32'(size_y_r) < MIN_SIZE)    ny = NYW'(MIN_SIZE);
    else if (32'(size_y_r) > MAX_NY) ny = NYW'(MAX_NY);
    else                             ny = NYW'(size_y_r);
    if (32'(size_z_r) < MIN_SIZE)    nz = SIZE_Z_BITS'(MIN_SIZE);
    else if (32'(size_z_r) > MAX_NZ) nz = SIZE_Z_BITS'(MAX_NZ);
    else                             nz = size_z_r;
  end

  // Position decode for the item at the input.
  logic [NXW-1:0] col_x;
  logic [NYW-1:0] row_x;
  logic           emit, is_last;

  always_comb begin
    col_x = NXW'(col_r);
    row_x = NYW'(row_r);
    emit = 1'b0;
    is_last = 1'b0;
    if (dims == DIMS_BITS'(1)) begin
      emit    = col_x >= NXW'(2);
      is_last = col_x == nx - NXW'(1);
    end else if (dims == DIMS_BITS'(2)) begin
      emit    = row_x >= NYW'(2) && col_x >= NXW'(1) && col_x <= nx - NXW'(2);
      is_last = row_x == ny - NYW'(1) && col_x == nx - NXW'(2);
    end else begin
      emit    = plane_r >= PLANE_BITS'(2) && row_x >= NYW'(1) && row_x <= ny - NYW'(2)
                && col_x >= NXW'(1) && col_x <= nx - NXW'(2);
      is_last = SIZE_Z_BITS'(plane_r) == nz - SIZE_Z_BITS'(1)
                && row_x == ny - NYW'(2) && col_x == nx - NXW'(2);
    end
  end

  // Store addresses: write slot and the stencil neighbors around the center.
  logic [AW-1:0] in_plane, wr_addr, ctr_addr, rd_addr;
  logic [2:0]    last_k;

  always_comb begin
    in_plane = AW'(row_r) * AW'(MAX_NX) + AW'(col_r);
    wr_addr  = (dims == DIMS_BITS'(3) && plane_r[0]) ? in_plane + AW'(PLANE) : in_plane;
    if (dims == DIMS_BITS'(1))      ctr_addr = in_plane - AW'(1);
    else if (dims == DIMS_BITS'(2)) ctr_addr = in_plane - AW'(MAX_NX);
    else                            ctr_addr = plane_r[0] ? in_plane : in_plane + AW'(PLANE);
    unique case (k_r)
      3'd0:    rd_addr = ctr_addr;
      3'd1:    rd_addr = ctr_addr - AW'(1);
      3'd2:    rd_addr = ctr_addr + AW'(1);
      3'd3:    rd_addr = ctr_addr - AW'(MAX_NX);
      3'd4:    rd_addr = ctr_addr + AW'(MAX_NX);
      default: rd_addr = wr_addr;
    endcase
    last_k = {dims, 1'b0} - 3'd1;
  end

  // Per-axis terms.
  logic [SAMPLE_BITS:0] outer, twice;
  logic [EW-1:0]        ad, msum_t;

  always_comb begin
    outer  = {1'b0, a_r} + {1'b0, cv_r};
    twice  = {ctr_r, 1'b0};
    ad     = (outer >= twice) ? EW'(outer - twice) : EW'(twice - outer);
    msum_t = EW'(outer) + EW'(twice);
  end

  // Store and ratio unit.
  logic [SAMPLE_BITS-1:0] rd_data;
  logic                   ratio_done;
  logic [FRAC_BITS:0]     ratio_sensor;

  jss_store #(.SAMPLE_BITS(SAMPLE_BITS), .DEPTH(DEPTH), .AW(AW)) u_store (
    .clk     (clk),
    .wr_en   (state_r == S_WR),
    .wr_addr (wr_addr),
    .wr_data (s_r),
    .rd_en   (state_r == S_RD),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  jss_ratio #(.SAMPLE_BITS(SAMPLE_BITS), .FRAC_BITS(FRAC_BITS)) u_ratio (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (state_r == S_RSTART),
    .dsum   (dsum_r),
    .msum   (msum_r),
    .done   (ratio_done),
    .sensor (ratio_sensor)
  );

  logic in_acc, cfg_acc, out_free;
  assign in_acc   = in_valid && !in_stall;
  assign cfg_acc  = cfg_valid && cfg_ready;
  assign out_free = !out_valid_r || !out_stall;

  // Sequencer, counters, registers and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dims_r      <= DIMS_RESET;
      size_x_r    <= SIZE_X_RESET;
      size_y_r    <= SIZE_Y_RESET;
      size_z_r    <= SIZE_Z_RESET;
      col_r       <= '0;
      row_r       <= '0;
      plane_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // A new result loads the output register; otherwise a taken result empties it.
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (cfg_acc) begin
            unique case (cfg_index)
              CFG_DIMENSIONS: dims_r   <= cfg_data[DIMS_BITS-1:0];
              CFG_SIZE_X:     size_x_r <= cfg_data[SIZE_XY_BITS-1:0];
              CFG_SIZE_Y:     size_y_r <= cfg_data[SIZE_XY_BITS-1:0];
              CFG_SIZE_Z:     size_z_r <= cfg_data[SIZE_Z_BITS-1:0];
              default: ;
            endcase
            col_r   <= '0;
            row_r   <= '0;
            plane_r <= '0;
          end else if (in_acc) begin
            s_r    <= in_sample;
            last_r <= is_last;
            k_r    <= '0;
            dsum_r <= '0;
            msum_r <= '0;
            state_r <= emit ? S_RD : S_WR;
          end
        end
        S_RD: state_r <= S_CAP;
        S_CAP: begin
          if (k_r == 3'd0) begin
            ctr_r   <= rd_data;
            k_r     <= 3'd1;
            state_r <= S_RD;
          end else if (k_r[0]) begin
            a_r <= rd_data;
            if (k_r == last_k) begin
              cv_r    <= s_r;
              state_r <= S_MUL;
            end else begin
              k_r     <= k_r + 3'd1;
              state_r <= S_RD;
            end
          end else begin
            cv_r    <= rd_data;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          dsq_r   <= ad * ad;
          msq_r   <= msum_t * msum_t;
          state_r <= S_ACC;
        end
        S_ACC: begin
          dsum_r <= dsum_r + ACCW'(dsq_r);
          msum_r <= msum_r + ACCW'(msq_r);
          if (k_r == last_k) begin
            state_r <= S_RSTART;
          end else begin
            k_r     <= k_r + 3'd1;
            state_r <= S_RD;
          end
        end
        S_RSTART: state_r <= S_RATIO;
        S_RATIO: begin
          if (ratio_done) begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          // The ratio unit holds its result until the next start.
          if (out_free) begin
            out_sensor_r <= ratio_sensor;
            out_last_r   <= last_r;
            state_r      <= S_WR;
          end
        end
        S_WR: begin
          // Store the sample, then step the raster position.
          if (col_x + NXW'(1) >= nx) begin
            col_r <= '0;
            if (dims != DIMS_BITS'(1)) begin
              if (row_x + NYW'(1) >= ny) begin
                row_r <= '0;
                if (dims == DIMS_BITS'(3)) begin
                  if (SIZE_Z_BITS'(plane_r) + SIZE_Z_BITS'(1) >= nz) plane_r <= '0;
                  else plane_r <= plane_r + PLANE_BITS'(1);
                end
              end else begin
                row_r <= row_r + RW'(1);
              end
            end
          end else begin
            col_r <= col_r + CW'(1);
          end
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall   = (state_r != S_IDLE);
  assign cfg_ready  = (state_r == S_IDLE) && !in_valid;
  assign out_valid  = out_valid_r;
  assign out_sensor = out_sensor_r;
  assign out_last   = out_last_r;

endmodule
